/* sv/sha256s_pkg.sv */
// shared types and constants of the sha-256 stream hasher
// depends on nothing; imported by the interfaces, the round unit and the top level
package sha256s_pkg;

  typedef logic [31:0] word_t;

  // working variables a..h of one compression
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } vars_t;

  // taps of the message schedule window used by one round
  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w9;
    word_t w14;
  } sched_t;

  localparam int unsigned NumRounds  = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam word_t HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

/* sv/sha256s_if.sv */
// valid/ready channels of the sha-256 stream hasher: byte beats in, digest word beats out
// depends on sha256s_pkg
interface sha256s_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256s_word_if;
  logic                valid;
  logic                ready;
  sha256s_pkg::word_t  digest_word;
  logic [2:0]          word_index;
  logic                last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* sv/sha256s_round.sv */
// shared round unit: one sha-256 compression round and one schedule expansion step
// depends on sha256s_pkg
module sha256s_round (
  input  sha256s_pkg::vars_t  vars_i,
  input  sha256s_pkg::word_t  k_i,
  input  sha256s_pkg::sched_t sched_i,
  output sha256s_pkg::vars_t  vars_o,
  output sha256s_pkg::word_t  wnew_o
);
  import sha256s_pkg::*;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  word_t big_s0, big_s1, ch, mj, t1, t2, sig0, sig1;

  always_comb begin
    big_s1 = rotr(vars_i.e, 6) ^ rotr(vars_i.e, 11) ^ rotr(vars_i.e, 25);
    ch     = (vars_i.e & vars_i.f) ^ (~vars_i.e & vars_i.g);
    t1     = vars_i.h + big_s1 + ch + k_i + sched_i.w0;
    big_s0 = rotr(vars_i.a, 2) ^ rotr(vars_i.a, 13) ^ rotr(vars_i.a, 22);
    mj     = (vars_i.a & vars_i.b) ^ (vars_i.a & vars_i.c) ^ (vars_i.b & vars_i.c);
    t2     = big_s0 + mj;

    vars_o.h = vars_i.g;
    vars_o.g = vars_i.f;
    vars_o.f = vars_i.e;
    vars_o.e = vars_i.d + t1;
    vars_o.d = vars_i.c;
    vars_o.c = vars_i.b;
    vars_o.b = vars_i.a;
    vars_o.a = t1 + t2;

    // schedule word sixteen places ahead of the one consumed this round
    sig0   = rotr(sched_i.w1, 7) ^ rotr(sched_i.w1, 18) ^ (sched_i.w1 >> 3);
    sig1   = rotr(sched_i.w14, 17) ^ rotr(sched_i.w14, 19) ^ (sched_i.w14 >> 10);
    wnew_o = sched_i.w0 + sig0 + sched_i.w9 + sig1;
  end

endmodule

/* sv/sha256_stream_hasher.sv */
// sha-256 over a byte stream: one byte beat per cycle while idle; each 64-byte block goes through
// 64 rounds in the shared round unit, then the chain add, one word per cycle;
// end of message: padding bytes plus one or two block compressions, then 8 digest beats
// in_i.ready is low after a full block beat until its chain add ends, and from an end
// beat until the last digest beat is taken; reset (async, active low) loads the initial hash
// values and clears counts and sequencer
module sha256_stream_hasher (
  input  logic clk_i,
  input  logic rst_ni,
  sha256s_byte_if.sink   in_i,
  sha256s_word_if.source out_o
);
  import sha256s_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;      // bytes in the current block
  logic [60:0] count_q, count_d;    // message byte count, wraps mod 2^61
  logic [5:0]  rnd_q, rnd_d;        // round counter, low bits reused for add and emit
  logic        pend_q, pend_d;      // end of message seen, padding under way
  logic        sent80_q, sent80_d;  // pad byte 0x80 already pushed
  logic [3:0]  len_q, len_d;        // length bytes pushed so far

  word_t h_q [8];
  word_t h_d [8];
  word_t v_q [8];                   // working variables a..h
  word_t v_d [8];
  word_t w_q [16];                  // block bytes, then schedule window
  word_t w_d [16];

  logic        push_en;
  logic [7:0]  push_byte;
  logic        block_full;
  logic [63:0] bit_len;

  vars_t  rv_in, rv_out;
  sched_t sched;
  word_t  wnew;

  assign rv_in = '{a: v_q[0], b: v_q[1], c: v_q[2], d: v_q[3],
                   e: v_q[4], f: v_q[5], g: v_q[6], h: v_q[7]};
  assign sched = '{w0: w_q[0], w1: w_q[1], w9: w_q[9], w14: w_q[14]};

  sha256s_round u_round (
    .vars_i  (rv_in),
    .k_i     (RoundK[rnd_q]),
    .sched_i (sched),
    .vars_o  (rv_out),
    .wnew_o  (wnew)
  );

  assign bit_len  = {count_q, 3'b000};
  assign in_i.ready = (state_q == S_IDLE);

  // digest words leave straight from the chain register, rotated per beat
  assign out_o.valid       = (state_q == S_EMIT);
  assign out_o.digest_word = h_q[0];
  assign out_o.word_index  = rnd_q[2:0];
  assign out_o.last_word   = (rnd_q[2:0] == 3'd7);

  // byte source for the block shift line: message byte or padding
  always_comb begin
    push_en   = 1'b0;
    push_byte = in_i.data_byte;
    if (state_q == S_IDLE) begin
      push_en = in_i.valid && in_i.byte_present;
    end else if (state_q == S_PAD) begin
      push_en = 1'b1;
      if (!sent80_q) begin
        push_byte = PadByte;
      end else if (len_q == 4'd0 && fill_q != 6'(LenOffset)) begin
        push_byte = 8'h00;
      end else begin
        // big-endian bit length, most significant byte first
        push_byte = bit_len[{~len_q[2:0], 3'b000} +: 8];
      end
    end
  end

  assign block_full = push_en && (fill_q == 6'(BlockBytes - 1));

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    count_d  = count_q;
    rnd_d    = rnd_q;
    pend_d   = pend_q;
    sent80_d = sent80_q;
    len_d    = len_q;
    h_d      = h_q;
    v_d      = v_q;
    w_d      = w_q;

    if (push_en) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_d[15] = {w_q[15][23:0], push_byte};
      fill_d  = fill_q + 6'd1;
    end

    if (block_full) begin
      for (int i = 0; i < 8; i++) begin
        v_d[i] = h_q[i];
      end
      rnd_d = '0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.byte_present) begin
            count_d = count_q + 61'd1;
          end
          if (in_i.end_of_message) begin
            pend_d = 1'b1;
          end
          if (block_full) begin
            state_d = S_ROUND;
          end else if (in_i.end_of_message) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (!sent80_q) begin
          sent80_d = 1'b1;
        end else if (len_q != 4'd0 || fill_q == 6'(LenOffset)) begin
          len_d = len_q + 4'd1;
        end
        if (block_full) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        v_d = '{rv_out.a, rv_out.b, rv_out.c, rv_out.d,
                rv_out.e, rv_out.f, rv_out.g, rv_out.h};
        for (int i = 0; i < 15; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[15] = wnew;
        rnd_d   = rnd_q + 6'd1;
        if (rnd_q == 6'(NumRounds - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        // one chain word per cycle: both arrays rotate so word 0 is always next
        for (int i = 0; i < 7; i++) begin
          h_d[i] = h_q[i+1];
          v_d[i] = v_q[i+1];
        end
        h_d[7] = h_q[0] + v_q[0];
        v_d[7] = v_q[0];
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q[2:0] == 3'd7) begin
          rnd_d = '0;
          if (!pend_q) begin
            state_d = S_IDLE;
          end else if (len_q == 4'd8) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_PAD;
          end
        end
      end
      S_EMIT: begin
        if (out_o.ready) begin
          for (int i = 0; i < 7; i++) begin
            h_d[i] = h_q[i+1];
          end
          h_d[7] = h_q[0];
          rnd_d  = rnd_q + 6'd1;
          if (rnd_q[2:0] == 3'd7) begin
            // digest delivered: start the next message
            h_d      = HashInit;
            rnd_d    = '0;
            count_d  = '0;
            fill_d   = '0;
            pend_d   = 1'b0;
            sent80_d = 1'b0;
            len_d    = '0;
            state_d  = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      count_q  <= '0;
      rnd_q    <= '0;
      pend_q   <= 1'b0;
      sent80_q <= 1'b0;
      len_q    <= '0;
      h_q      <= HashInit;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      count_q  <= count_d;
      rnd_q    <= rnd_d;
      pend_q   <= pend_d;
      sent80_q <= sent80_d;
      len_q    <= len_d;
      h_q      <= h_d;
    end
  end

  // working storage, written before it is read
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

endmodule
